### rtl/core/jdse_pkg.sv
// Package for the JTAG data shift engine: beat types, request codes and helpers.
// No dependencies; compile first.
package jdse_pkg;

    // Request codes carried in req_type
    typedef enum logic [0:0] {
        REQ_START = 1'b0,
        REQ_BYTE  = 1'b1
    } req_type_t;

    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned CLK_CNT_W = 4;

    // One input beat
    typedef struct packed {
        req_type_t                req_type;
        logic [CNT_W-1:0]         num_bits;
        logic                     host_sends;
        logic                     host_receives;
        logic                     exit_on_last;
        logic                     fill_ones;
        logic [BYTE_BITS-1:0]     tdi_byte;
        logic [BYTE_BITS-1:0]     tdo_levels;
    } cmd_item_t;

    // One result beat
    typedef struct packed {
        logic [BYTE_BITS-1:0]     tdi_bits;
        logic [BYTE_BITS-1:0]     tms_bits;
        logic [CLK_CNT_W-1:0]     clock_count;
        logic [BYTE_BITS-1:0]     captured_tdo;
        logic                     capture_valid;
        logic                     shift_done;
    } rsp_item_t;

    // Mask with the low n bits set, n from 1 to 8
    function automatic logic [BYTE_BITS-1:0] low_mask(input logic [CLK_CNT_W-1:0] n);
        logic [CLK_CNT_W-1:0] gap;
        gap = CLK_CNT_W'(BYTE_BITS) - n;
        return {BYTE_BITS{1'b1}} >> gap;
    endfunction

endpackage

### rtl/core/jdse_ifs.sv
// Valid/ready channel interfaces for the JTAG data shift engine.
// Depends on jdse_pkg.
interface jdse_cmd_if import jdse_pkg::*; ();
    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface jdse_rsp_if import jdse_pkg::*; ();
    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/jtag_data_shift_engine.sv
// Channel   | Dir | Payload     | Notes
// cmd       | in  | cmd_item_t  | start beats arm a shift, byte beats clock up to 8 bits
// rsp       | out | rsp_item_t  | one beat per byte beat taken while a shift is armed
//
// The result of an accepted byte beat is loaded into the output register in the following cycle.
// A new beat is taken every cycle while the output register is empty or being read.
// Start beats and byte beats while idle produce no result.
// rst_n clears the shift state and empties the output register.
// Depends on jdse_pkg and jdse_ifs.
module jtag_data_shift_engine import jdse_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    jdse_cmd_if.sink   cmd,
    jdse_rsp_if.source rsp
);

    logic [CNT_W-1:0]     bits_left_reg, bits_left_next;
    logic                 mode_send_reg, mode_send_next;
    logic                 mode_receive_reg, mode_receive_next;
    logic                 flag_exit_last_reg, flag_exit_last_next;
    logic                 flag_fill_ones_reg, flag_fill_ones_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_item_t            out_data_reg, out_data_next;

    logic                 accept;
    logic                 busy;
    logic                 last;
    logic [CLK_CNT_W-1:0] n_clk;
    logic [BYTE_BITS-1:0] mask;
    logic [BYTE_BITS-1:0] tdi_raw;
    logic [2:0]           last_pos;

    // output register frees up when empty or being read
    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign busy      = (bits_left_reg != '0);

    // clocks for this byte
    assign last     = (bits_left_reg[CNT_W-1:3] == '0) || (bits_left_reg == CNT_W'(BYTE_BITS));
    assign n_clk    = last ? bits_left_reg[CLK_CNT_W-1:0] : CLK_CNT_W'(BYTE_BITS);
    assign mask     = low_mask(n_clk);
    assign last_pos = 3'(n_clk - CLK_CNT_W'(1));
    assign tdi_raw  = mode_send_reg ? cmd.data.tdi_byte
                                    : {BYTE_BITS{flag_fill_ones_reg}};

    // next state and result
    always_comb
    begin
        bits_left_next      = bits_left_reg;
        mode_send_next      = mode_send_reg;
        mode_receive_next   = mode_receive_reg;
        flag_exit_last_next = flag_exit_last_reg;
        flag_fill_ones_next = flag_fill_ones_reg;
        out_valid_next      = out_valid_reg && !rsp.ready;
        out_data_next       = out_data_reg;

        if (accept)
        begin
            case (cmd.data.req_type)
                REQ_START:
                begin
                    if (cmd.data.num_bits != '0)
                    begin
                        bits_left_next      = cmd.data.num_bits;
                        mode_send_next      = cmd.data.host_sends;
                        mode_receive_next   = cmd.data.host_receives;
                        flag_exit_last_next = cmd.data.exit_on_last;
                        flag_fill_ones_next = cmd.data.fill_ones;
                    end
                end
                REQ_BYTE:
                begin
                    if (busy)
                    begin
                        out_valid_next             = 1'b1;
                        out_data_next.tdi_bits     = tdi_raw & mask;
                        out_data_next.tms_bits     = (last && flag_exit_last_reg)
                                                   ? (BYTE_BITS'(1) << last_pos) : '0;
                        out_data_next.clock_count  = n_clk;
                        out_data_next.captured_tdo = mode_receive_reg
                                                   ? (cmd.data.tdo_levels & mask) : '0;
                        out_data_next.capture_valid = mode_receive_reg;
                        out_data_next.shift_done   = last;
                        bits_left_next             = bits_left_reg - CNT_W'(n_clk);
                    end
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !rsp.ready;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_left_reg      <= '0;
            mode_send_reg      <= 1'b0;
            mode_receive_reg   <= 1'b0;
            flag_exit_last_reg <= 1'b0;
            flag_fill_ones_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            bits_left_reg      <= bits_left_next;
            mode_send_reg      <= mode_send_next;
            mode_receive_reg   <= mode_receive_next;
            flag_exit_last_reg <= flag_exit_last_next;
            flag_fill_ones_reg <= flag_fill_ones_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

### rtl/core/jdse_checker.sv
// Port-level checks for the JTAG data shift engine, bound into the jtag_data_shift_engine module.
// Depends on jdse_pkg and jtag_data_shift_engine.
module jdse_port_checks import jdse_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_item_t rsp_data
);

    // a held result beat stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped while stalled");

    // clock count within one byte
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.clock_count >= 4'd1) && (rsp_data.clock_count <= 4'd8))
        else $error("clock count out of range");

    // TMS only on the final byte of a shift
    a_tms_final: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.shift_done |-> (rsp_data.tms_bits == '0))
        else $error("TMS raised before the final byte");

    // partial byte leaves unused bits clear
    a_unused_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.clock_count < 4'd8) |->
            ((rsp_data.tdi_bits >> rsp_data.clock_count) == '0) &&
            ((rsp_data.captured_tdo >> rsp_data.clock_count) == '0))
        else $error("bits beyond clock count not zero");

    // nothing captured when not receiving
    a_no_capture: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.capture_valid |-> (rsp_data.captured_tdo == '0))
        else $error("captured TDO present while not receiving");

endmodule

bind jtag_data_shift_engine jdse_port_checks u_jdse_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

### verif/jdse_checker.sv
// Scoreboard for the JTAG data shift engine: watches the command and result channels,
// predicts every result beat from the command beats and compares them field by field.
// Depends on jdse_pkg and jdse_ifs.
module jdse_checker import jdse_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    jdse_cmd_if  cmd,
    jdse_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding,
    output int   starts_seen,
    output int   bytes_seen,
    output int   results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the engine's shift state
    logic [CNT_W-1:0] bits_left;
    logic             send_mode;
    logic             recv_mode;
    logic             exit_last;
    logic             fill_one;

    // Predicted result beats, oldest first
    rsp_item_t shift_results_q[$];

    // Advance the shadow state by one command beat; returns 1 when a result is due
    function automatic bit predict_shift(input cmd_item_t b, output rsp_item_t r);
        logic [CLK_CNT_W-1:0] clocks;
        logic [BYTE_BITS-1:0] keep;
        logic [BYTE_BITS-1:0] drive;
        bit                   final_byte;
        r = '0;
        if (b.req_type == REQ_START) begin
            // a zero-length start leaves everything as it was
            if (b.num_bits != '0) begin
                bits_left = b.num_bits;
                send_mode = b.host_sends;
                recv_mode = b.host_receives;
                exit_last = b.exit_on_last;
                fill_one  = b.fill_ones;
            end
            return 1'b0;
        end
        // byte beats while idle are dropped
        if (bits_left == '0)
            return 1'b0;
        final_byte = (bits_left <= CNT_W'(BYTE_BITS));
        clocks = final_byte ? bits_left[CLK_CNT_W-1:0] : CLK_CNT_W'(BYTE_BITS);
        keep   = BYTE_BITS'((9'd1 << clocks) - 9'd1);
        if (send_mode)
            drive = b.tdi_byte;
        else
            drive = fill_one ? {BYTE_BITS{1'b1}} : '0;
        r.tdi_bits      = drive & keep;
        r.tms_bits      = (final_byte && exit_last) ? BYTE_BITS'(9'd1 << (clocks - 1)) : '0;
        r.clock_count   = clocks;
        r.captured_tdo  = recv_mode ? (b.tdo_levels & keep) : '0;
        r.capture_valid = recv_mode;
        r.shift_done    = final_byte;
        bits_left = bits_left - CNT_W'(clocks);
        return 1'b1;
    endfunction

    // Compare result beats first (they come from earlier commands), then predict
    always @(posedge clk or negedge rst_n) begin
        rsp_item_t want;
        rsp_item_t got;
        if (!rst_n) begin
            bits_left = '0;
            send_mode = 1'b0;
            recv_mode = 1'b0;
            exit_last = 1'b0;
            fill_one  = 1'b0;
            shift_results_q.delete();
            outstanding = 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                got = rsp.data;
                results_checked++;
                if (shift_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat tdi=%h tms=%h clk=%0d cap=%h cv=%b done=%b",
                                 $time, got.tdi_bits, got.tms_bits, got.clock_count,
                                 got.captured_tdo, got.capture_valid, got.shift_done);
                end else begin
                    want = shift_results_q.pop_front();
                    if (got.tdi_bits !== want.tdi_bits || got.tms_bits !== want.tms_bits ||
                        got.clock_count !== want.clock_count ||
                        got.captured_tdo !== want.captured_tdo ||
                        got.capture_valid !== want.capture_valid ||
                        got.shift_done !== want.shift_done) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected tdi=%h tms=%h clk=%0d cap=%h cv=%b done=%b",
                                     want.tdi_bits, want.tms_bits, want.clock_count,
                                     want.captured_tdo, want.capture_valid, want.shift_done);
                            $display("  actual   tdi=%h tms=%h clk=%0d cap=%h cv=%b done=%b",
                                     got.tdi_bits, got.tms_bits, got.clock_count,
                                     got.captured_tdo, got.capture_valid, got.shift_done);
                        end
                    end
                end
            end
            if (cmd.valid && cmd.ready) begin
                if (cmd.data.req_type == REQ_START)
                    starts_seen++;
                else
                    bytes_seen++;
                if (predict_shift(cmd.data, want))
                    shift_results_q.push_back(want);
            end
            outstanding = shift_results_q.size();
        end
    end

endmodule

### verif/tb_top.sv
// Top of the JTAG data shift engine testbench: clock, reset, command stimulus,
// result back-pressure, watchdog and verdict. Depends on jdse_pkg, jdse_ifs,
// jdse_checker and the engine itself.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jdse_pkg::*;

    localparam int ITEMS_PER_PHASE = 270;
    localparam int QUIET_LIMIT     = 5000;

    logic clk = 1'b0;
    logic rst_n;

    int src_idle_pct;
    int snk_idle_pct;
    int mismatches;
    int outstanding;
    int starts_seen;
    int bytes_seen;
    int results_checked;

    jdse_cmd_if cmd_ch();
    jdse_rsp_if rsp_ch();

    jtag_data_shift_engine uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    jdse_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd_ch),
        .rsp             (rsp_ch),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .starts_seen     (starts_seen),
        .bytes_seen      (bytes_seen),
        .results_checked (results_checked)
    );

    always #2 clk = ~clk;

    // Result back-pressure
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

    // Start beat; the byte fields are don't-care and get random content
    function automatic cmd_item_t start_beat(input logic [CNT_W-1:0] nbits, input logic snd,
                                             input logic rcv, input logic ext, input logic one);
        cmd_item_t b;
        b.req_type      = REQ_START;
        b.num_bits      = nbits;
        b.host_sends    = snd;
        b.host_receives = rcv;
        b.exit_on_last  = ext;
        b.fill_ones     = one;
        b.tdi_byte      = BYTE_BITS'($urandom);
        b.tdo_levels    = BYTE_BITS'($urandom);
        return b;
    endfunction

    // Byte beat; count and flags are don't-care and get random content
    function automatic cmd_item_t byte_beat(input logic [BYTE_BITS-1:0] tdi,
                                            input logic [BYTE_BITS-1:0] tdo);
        cmd_item_t b;
        b.req_type      = REQ_BYTE;
        b.num_bits      = $urandom;
        b.host_sends    = 1'($urandom_range(0, 1));
        b.host_receives = 1'($urandom_range(0, 1));
        b.exit_on_last  = 1'($urandom_range(0, 1));
        b.fill_ones     = 1'($urandom_range(0, 1));
        b.tdi_byte      = tdi;
        b.tdo_levels    = tdo;
        return b;
    endfunction

    function automatic cmd_item_t rand_byte();
        return byte_beat(BYTE_BITS'($urandom), BYTE_BITS'($urandom));
    endfunction

    function automatic cmd_item_t rand_start(input logic [CNT_W-1:0] nbits);
        return start_beat(nbits, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // Present one beat from a falling edge and hold it until taken; returns at a falling edge
    task automatic put_beat(input cmd_item_t b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= b;
        do @(posedge clk); while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    // Hold off the command side until every predicted result beat has come back
    task automatic drain_pause();
        cmd_ch.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    // Mostly complete shifts with random payload, plus abandoned shifts and stray beats
    task automatic run_random_shifts(input int target);
        int               counted;
        int               pick;
        int               nbytes;
        logic [CNT_W-1:0] nbits;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                put_beat(rand_start('0));
            end else if (pick < 8) begin
                put_beat(rand_byte());
            end else begin
                if (pick < 14)
                    nbits = $urandom;
                else if (pick < 24)
                    nbits = $urandom_range(41, 255);
                else
                    nbits = $urandom_range(1, 40);
                if (nbits == '0)
                    nbits = 1;
                nbytes = (nbits > 255) ? $urandom_range(1, 5) : int'((nbits + 7) / 8);
                pick = $urandom_range(0, 99);
                // cut the shift short now and then; the next start replaces it
                if (pick < 8)
                    nbytes = $urandom_range(0, nbytes - 1);
                put_beat(rand_start(nbits));
                counted++;
                repeat (nbytes) begin
                    put_beat(rand_byte());
                    counted++;
                end
                // one byte too many: dropped when the shift has finished
                if (pick >= 92)
                    put_beat(rand_byte());
                if ($urandom_range(0, 49) == 0)
                    drain_pause();
            end
        end
    endtask

    // Watchdog: stop when no beat moves on either channel for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: %0d cycles without a beat, %0d results outstanding",
                 QUIET_LIMIT, outstanding);
        $display("jtag_data_shift_engine regression: fail");
        $finish;
    end

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        rst_n        = 1'b0;
        src_idle_pct = 12;
        snk_idle_pct = 87;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // byte while idle, then zero-length start: both dropped
        put_beat(byte_beat(8'hFF, 8'hFF));
        put_beat(start_beat('0, 1'b1, 1'b1, 1'b1, 1'b1));
        put_beat(byte_beat(8'hFF, 8'hFF));
        // single-bit shift with exit on last
        put_beat(start_beat(32'd1, 1'b1, 1'b1, 1'b1, 1'b0));
        put_beat(byte_beat(8'hFF, 8'hFF));
        // one full byte filled with ones, no capture
        put_beat(start_beat(32'd8, 1'b0, 1'b0, 1'b1, 1'b1));
        put_beat(byte_beat(8'h00, 8'hFF));
        // nine bits: full byte then a one-bit tail
        put_beat(start_beat(32'd9, 1'b1, 1'b1, 1'b0, 1'b0));
        put_beat(byte_beat(8'hAA, 8'h55));
        put_beat(byte_beat(8'hFF, 8'hFF));
        // zero fill, with a zero-length start in the middle that must not disturb it
        put_beat(start_beat(32'd16, 1'b0, 1'b1, 1'b1, 1'b0));
        put_beat(byte_beat(8'hFF, 8'h00));
        put_beat(start_beat('0, 1'b1, 1'b0, 1'b0, 1'b1));
        put_beat(byte_beat(8'h00, 8'hFF));
        put_beat(byte_beat(8'hFF, 8'hFF));
        // longest count, abandoned for a short three-bit shift
        put_beat(start_beat(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1));
        put_beat(byte_beat(8'h00, 8'h00));
        put_beat(byte_beat(8'hFF, 8'hFF));
        put_beat(start_beat(32'd3, 1'b1, 1'b1, 1'b1, 1'b0));
        put_beat(byte_beat(8'hFF, 8'hFF));
        put_beat(byte_beat(8'hFF, 8'hFF));
        // seven-bit partial byte, fill with ones
        put_beat(start_beat(32'd7, 1'b0, 1'b1, 1'b0, 1'b1));
        put_beat(byte_beat(8'h00, 8'h80));
        drain_pause();

        // busy sender against a mostly stalled receiver
        run_random_shifts(ITEMS_PER_PHASE);
        drain_pause();

        // slow sender against a mostly ready receiver
        src_idle_pct = 87;
        snk_idle_pct = 12;
        run_random_shifts(ITEMS_PER_PHASE);
        drain_pause();

        // both sides flat out
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random_shifts(ITEMS_PER_PHASE);
        drain_pause();

        repeat (4) @(posedge clk);
        $display("covered %0d start beats and %0d byte beats; %0d result beats checked",
                 starts_seen, bytes_seen, results_checked);
        $display("%0d mismatches, %0d results outstanding", mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("jtag_data_shift_engine regression: pass");
        else
            $display("jtag_data_shift_engine regression: fail");
        $finish;
    end

endmodule
